// ===== hdl/htbd_pkg.sv =====
// Package for the Huffman tree bit decoder: field widths, stream packing,
// node record, command/status structs and small helper functions.
// No dependencies.
`default_nettype none

package htbd_pkg;

  localparam int unsigned NODE_W        = 9;
  localparam int unsigned SYM_W         = 32;
  localparam int unsigned LEN_W         = 3;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LIMIT_W       = 32;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned CNT_W         = 4;   // holds 0..BITS_PER_BYTE
  localparam int unsigned MAX_LEN       = 4;

  // Input stream tdata layout, lowest bit first
  localparam int unsigned IDX_LSB   = 0;
  localparam int unsigned LEFT_LSB  = IDX_LSB + NODE_W;
  localparam int unsigned RIGHT_LSB = LEFT_LSB + NODE_W;
  localparam int unsigned LEAF_LSB  = RIGHT_LSB + NODE_W;
  localparam int unsigned SYM_LSB   = LEAF_LSB + 1;
  localparam int unsigned LEN_LSB   = SYM_LSB + SYM_W;
  localparam int unsigned BYTE_LSB  = LEN_LSB + LEN_W;
  localparam int unsigned IN_USED_W = BYTE_LSB + BYTE_W;
  localparam int unsigned IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output stream tdata layout
  localparam int unsigned OUT_USED_W = SYM_W + LEN_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam int unsigned OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_DECODE = 2'd1,
    OP_START  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  len;
  } node_t;

  localparam int unsigned NODE_DATA_W = $bits(node_t);

  // controller -> datapath
  typedef struct packed {
    logic take;    // input request accepted this cycle
    logic walk;    // walking the tree, one coded bit per cycle unless stalled
    logic flush;   // hand the held symbol to the output as last of byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_step;
    logic stall;
    logic pend_valid;
    logic out_busy;
  } sts_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) r = LEN_W'(1);
    else if (len > LEN_W'(MAX_LEN)) r = LEN_W'(MAX_LEN);
    return r;
  endfunction

  // keep only the first len bytes; len is already clamped to 1..4
  function automatic logic [SYM_W-1:0] mask_sym(input logic [SYM_W-1:0] sym,
                                                input logic [LEN_W-1:0] len);
    logic [SYM_W-1:0] m;
    case (len)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return sym & m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/huffman_tree_bit_decoder.sv =====
// Top level of the Huffman tree bit decoder: controller plus datapath.
// Depends on htbd_pkg, htbd_ctrl, htbd_dp (and htbd_ram below it).
//
//  channel  dir  fields
//  s_axis   in   tuser: operation; tdata: node fields and data byte
//  m_axis   out  tdata: symbol; tlast: last of byte; tuser: stream done
//  cfg      in   bit_limit, written on cfg_we_i
//
// Node write and start requests leave the block idle, ready for the next one.
// A decode request is accepted, then the walk takes one coded bit per cycle
// unless stalled (at most 8: each step reads the child from the single read port
// of the node store, registered), then tests the last node reached, and a flush
// hands over the held symbol; no new request is taken until the flush ends.
// Output back-pressure holds the walk only when a second symbol is ready
// while the output register and the held symbol are both full, and holds
// the flush until the output register is free.
// Reset is asynchronous; the node store is not cleared and has no clear pass.
`default_nettype none

module huffman_tree_bit_decoder #(
  parameter int unsigned NODE_COUNT = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: node_index, left_child, right_child, is_leaf, leaf_symbol,
  //        leaf_length, data_byte, zero pad
  input  wire logic [htbd_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: operation
  input  wire logic [htbd_pkg::OP_W-1:0]      s_axis_tuser_i,
  // master stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: symbol_value, symbol_length, zero pad
  output logic [htbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // tuser: stream_done
  output logic                                m_axis_tuser_o,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [htbd_pkg::LIMIT_W-1:0]   cfg_wdata_i
);
  import htbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  htbd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  htbd_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .sts_o           (sts)
  );

  // no symbol may be left held once the block takes new requests
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !sts.pend_valid)
    else $error("held symbol left over while idle");

  // an accepted decode request keeps the input closed the next cycle
  a_decode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (op_e'(s_axis_tuser_i) == OP_DECODE))
    |=> !s_axis_tready_o)
    else $error("decode request did not start a walk");

  // a stalled walk stays in the walk
  a_stall_holds_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.stall |=> cmd.walk)
    else $error("walk left while stalled");

endmodule

`default_nettype wire

// ===== hdl/htbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module htbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/htbd_ctrl.sv =====
// Controller state machine of the tree decoder: sequences accept, tree walk
// and final flush. Depends on htbd_pkg.
`default_nettype none

module htbd_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic [htbd_pkg::OP_W-1:0]     s_axis_tuser_i,
  output logic                               s_axis_tready_o,
  input  wire htbd_pkg::sts_t                sts_i,
  output htbd_pkg::cmd_t                     cmd_o
);
  import htbd_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cmd_o.take  = take;
    cmd_o.walk  = (state_q == ST_WALK);
    cmd_o.flush = (state_q == ST_FLUSH);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (op_e'(s_axis_tuser_i) == OP_DECODE)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!sts_i.stall && !sts_i.can_step) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid || !sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/htbd_dp.sv =====
// Datapath of the tree decoder: node store, walk position, bit counter,
// held symbol and output register. Depends on htbd_pkg and htbd_ram.
`default_nettype none

module htbd_dp #(
  parameter int unsigned NODE_COUNT = 512
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire htbd_pkg::cmd_t                     cmd_i,
  input  wire logic [htbd_pkg::OP_W-1:0]          s_axis_tuser_i,
  input  wire logic [htbd_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [htbd_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  wire logic                               m_axis_tready_i,
  output logic                                    m_axis_tvalid_o,
  output logic [htbd_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  output logic                                    m_axis_tlast_o,
  output logic                                    m_axis_tuser_o,
  output htbd_pkg::sts_t                          sts_o
);
  import htbd_pkg::*;

  localparam int unsigned AW = $clog2(NODE_COUNT);
  // wide enough for any node index and for NODE_COUNT itself
  localparam int unsigned XW = ((AW > NODE_W) ? AW : NODE_W) + 1;
  localparam logic [XW-1:0] NC_X = XW'(NODE_COUNT);

  // input fields
  op_e              op;
  logic [NODE_W-1:0] in_idx, in_left, in_right;
  logic              in_leaf;
  logic [SYM_W-1:0]  in_sym;
  logic [LEN_W-1:0]  in_len, in_len_c;
  logic [BYTE_W-1:0] in_byte;

  assign op       = op_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[IDX_LSB +: NODE_W];
  assign in_left  = s_axis_tdata_i[LEFT_LSB +: NODE_W];
  assign in_right = s_axis_tdata_i[RIGHT_LSB +: NODE_W];
  assign in_leaf  = s_axis_tdata_i[LEAF_LSB];
  assign in_sym   = s_axis_tdata_i[SYM_LSB +: SYM_W];
  assign in_len   = s_axis_tdata_i[LEN_LSB +: LEN_W];
  assign in_byte  = s_axis_tdata_i[BYTE_LSB +: BYTE_W];
  assign in_len_c = clamp_len(in_len);

  // state
  logic [NODE_W-1:0]  cur_idx_q, cur_idx_d;
  logic [LIMIT_W-1:0] bits_q, bits_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               step_q, step_d;
  logic               oor_q;
  logic [NODE_W-1:0]  root_left_q, root_right_q;

  logic               pend_v_q, pend_v_d;
  logic [SYM_W-1:0]   pend_sym_q, pend_sym_d;
  logic [LEN_W-1:0]   pend_len_q, pend_len_d;
  logic               pend_done_q, pend_done_d;

  logic               out_v_q, out_v_d;
  logic [SYM_W-1:0]   out_sym_q, out_sym_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic               out_last_q, out_last_d;
  logic               out_done_q, out_done_d;

  // node store
  node_t             wr_node, rd_raw, nd;
  logic [XW-1:0]     wr_idx_x, rd_idx_x;
  logic              wr_en;
  logic [NODE_W-1:0] rd_idx;

  assign wr_idx_x = XW'(in_idx);
  assign wr_en    = cmd_i.take && (op == OP_WRITE) && (wr_idx_x < NC_X);

  always_comb begin
    wr_node.left   = in_left;
    wr_node.right  = in_right;
    wr_node.leaf   = in_leaf;
    wr_node.symbol = mask_sym(in_sym, in_len_c);
    wr_node.len    = in_len_c;
  end

  htbd_ram #(
    .WIDTH (NODE_DATA_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx_x[AW-1:0]),
    .wdata_i (wr_node),
    .raddr_i (rd_idx_x[AW-1:0]),
    .rdata_o (rd_raw)
  );

  // walk step
  logic              leaf, can_step, out_busy, stall, step_go;
  logic [NODE_W-1:0] cl, cr, child;

  // an index past the store reads as an all-zero node
  assign nd       = oor_q ? '0 : rd_raw;
  // only a node reached by a bit can emit
  assign leaf     = step_q && nd.leaf;
  assign cl       = leaf ? root_left_q  : nd.left;
  assign cr       = leaf ? root_right_q : nd.right;
  assign child    = byte_q[BYTE_W-1] ? cr : cl;
  assign can_step = (rem_q != '0) && (bits_q < limit_q);
  assign out_busy = out_v_q && !m_axis_tready_i;
  assign stall    = cmd_i.walk && leaf && pend_v_q && out_busy;
  assign step_go  = cmd_i.walk && !stall && can_step;

  // on stall the same address is read again, so read data holds
  assign rd_idx   = step_go ? child : cur_idx_q;
  assign rd_idx_x = XW'(rd_idx);

  always_comb begin
    cur_idx_d   = cur_idx_q;
    bits_d      = bits_q;
    rem_d       = rem_q;
    byte_d      = byte_q;
    step_d      = step_q;
    pend_v_d    = pend_v_q;
    pend_sym_d  = pend_sym_q;
    pend_len_d  = pend_len_q;
    pend_done_d = pend_done_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_sym_d   = out_sym_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;

    if (cmd_i.take) begin
      case (op)
        OP_START: begin
          cur_idx_d = '0;
          bits_d    = '0;
        end
        OP_DECODE: begin
          byte_d = in_byte;
          rem_d  = CNT_W'(BITS_PER_BYTE);
          step_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.walk && !stall) begin
      if (leaf) begin
        if (pend_v_q) begin
          out_v_d    = 1'b1;
          out_sym_d  = pend_sym_q;
          out_len_d  = pend_len_q;
          out_last_d = 1'b0;
          out_done_d = pend_done_q;
        end
        pend_v_d    = 1'b1;
        pend_sym_d  = nd.symbol;
        pend_len_d  = nd.len;
        pend_done_d = (bits_q >= limit_q);
      end
      if (step_go) begin
        cur_idx_d = child;
        bits_d    = bits_q + LIMIT_W'(1);
        rem_d     = rem_q - CNT_W'(1);
        byte_d    = {byte_q[BYTE_W-2:0], 1'b0};
        step_d    = 1'b1;
      end else if (leaf) begin
        cur_idx_d = '0;
      end
    end

    if (cmd_i.flush && pend_v_q && !out_busy) begin
      out_v_d    = 1'b1;
      out_sym_d  = pend_sym_q;
      out_len_d  = pend_len_q;
      out_last_d = 1'b1;
      out_done_d = pend_done_q;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q <= '0;
      bits_q    <= '0;
      limit_q   <= '0;
      rem_q     <= '0;
      step_q    <= 1'b0;
      oor_q     <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      cur_idx_q <= cur_idx_d;
      bits_q    <= bits_d;
      rem_q     <= rem_d;
      step_q    <= step_d;
      oor_q     <= !(rd_idx_x < NC_X);
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_sym_q  <= pend_sym_d;
    pend_len_q  <= pend_len_d;
    pend_done_q <= pend_done_d;
    out_sym_q   <= out_sym_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    // shadow of the root's children, so a leaf hit can step on at once
    if (wr_en && (in_idx == '0)) begin
      root_left_q  <= in_left;
      root_right_q <= in_right;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_len_q, out_sym_q});
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

  always_comb begin
    sts_o.can_step   = can_step;
    sts_o.stall      = stall;
    sts_o.pend_valid = pend_v_q;
    sts_o.out_busy   = out_busy;
  end

endmodule

`default_nettype wire
